// ----- hw/rtl/pcfc_pkg.sv -----
// palette color format converter: shared types, codes and constants
// no dependencies; imported by every module of the converter
`timescale 1ns / 1ps
`default_nettype none

package pcfc_pkg;

    localparam int COLOR_W  = 32;
    localparam int HALF_W   = 16;
    localparam int CH_W     = 8;
    localparam int NUM_CH   = 4;
    localparam int QUOT_W   = 4;
    localparam int FIELD5_W = 5;

    // byte lanes of the 32-bit abgr word
    localparam int CH_R = 0;
    localparam int CH_G = 1;
    localparam int CH_B = 2;
    localparam int CH_A = 3;

    // floor(x / 17) for 8-bit x equals (x * 241) >> 12
    localparam logic [CH_W-1:0] RECIP17     = 8'd241;
    localparam int              RECIP_SHIFT = 12;
    localparam int              PROD_W      = 2 * CH_W;

    localparam logic OP_WIDEN = 1'b0;
    localparam logic OP_PACK  = 1'b1;

    localparam logic [1:0] MODE_RESET = 2'd0;

    typedef enum logic [1:0] {
        MODE_ARGB4444    = 2'd0,
        MODE_BGR555_SWAP = 2'd1,
        MODE_RGB555      = 2'd2
    } color_mode_t;

    typedef struct packed {
        logic        op;
        color_mode_t mode;
    } pcfc_ctl_t;

    typedef logic [NUM_CH-1:0][QUOT_W-1:0] pcfc_quot_t;

    function automatic logic [QUOT_W-1:0] div17(input logic [CH_W-1:0] x);
        logic [PROD_W-1:0] p;
        p = PROD_W'(x) * PROD_W'(RECIP17);
        return p[RECIP_SHIFT +: QUOT_W];
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/pcfc_recip_stage.sv -----
// second pipeline stage: per-byte divide by 17 through reciprocal multiply
// depends on pcfc_pkg
`timescale 1ns / 1ps
`default_nettype none

module pcfc_recip_stage (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       in_valid,
    output logic                      in_ready,
    input  pcfc_pkg::pcfc_ctl_t       in_ctl,
    input  wire [pcfc_pkg::COLOR_W-1:0] in_color,
    output logic                      out_valid,
    input  wire                       out_ready,
    output pcfc_pkg::pcfc_ctl_t       out_ctl,
    output logic [pcfc_pkg::COLOR_W-1:0] out_color,
    output pcfc_pkg::pcfc_quot_t      out_quot
);
    import pcfc_pkg::*;

    logic       valid_reg;
    pcfc_ctl_t  ctl_reg;
    logic [COLOR_W-1:0] color_reg;
    pcfc_quot_t quot_reg;
    pcfc_quot_t quot_next;

    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            quot_next[i] = div17(in_color[i*CH_W +: CH_W]);
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            ctl_reg   <= in_ctl;
            color_reg <= in_color;
            quot_reg  <= quot_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_color = color_reg;
    assign out_quot  = quot_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/pcfc_assemble_stage.sv -----
// last pipeline stage: field expansion, packing and byte swap into the output register
// depends on pcfc_pkg
`timescale 1ns / 1ps
`default_nettype none

module pcfc_assemble_stage (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       in_valid,
    output logic                      in_ready,
    input  pcfc_pkg::pcfc_ctl_t       in_ctl,
    input  wire [pcfc_pkg::COLOR_W-1:0] in_color,
    input  pcfc_pkg::pcfc_quot_t      in_quot,
    output logic                      out_valid,
    input  wire                       out_ready,
    output logic [pcfc_pkg::COLOR_W-1:0] out_color
);
    import pcfc_pkg::*;

    logic               valid_reg;
    logic [COLOR_W-1:0] color_reg;
    logic [COLOR_W-1:0] color_next;

    logic [HALF_W-1:0]   w_raw;
    logic [HALF_W-1:0]   w_swap;
    logic [HALF_W-1:0]   w555;
    logic [FIELD5_W-1:0] f_hi, f_mid, f_lo;
    logic [CH_W-1:0]     e_hi, e_mid, e_lo;
    logic [FIELD5_W-1:0] p_r, p_g, p_b;
    logic [HALF_W-1:0]   pk_bgr, pk_rgb;

    always_comb begin
        w_raw  = in_color[HALF_W-1:0];
        w_swap = {w_raw[CH_W-1:0], w_raw[HALF_W-1:CH_W]};
        w555   = (in_ctl.mode == MODE_BGR555_SWAP) ? w_swap : w_raw;
        f_hi   = w555[14:10];
        f_mid  = w555[9:5];
        f_lo   = w555[4:0];
        // 5 to 8 bits: x*8 + x/4
        e_hi   = {f_hi, f_hi[4:2]};
        e_mid  = {f_mid, f_mid[4:2]};
        e_lo   = {f_lo, f_lo[4:2]};

        p_r    = in_color[CH_R*CH_W + 3 +: FIELD5_W];
        p_g    = in_color[CH_G*CH_W + 3 +: FIELD5_W];
        p_b    = in_color[CH_B*CH_W + 3 +: FIELD5_W];
        pk_rgb = {1'b0, p_r, p_g, p_b};
        pk_bgr = {1'b0, p_b, p_g, p_r};

        color_next = '0;
        if (in_ctl.op == OP_WIDEN) begin
            unique case (in_ctl.mode)
                MODE_ARGB4444: begin
                    color_next = {w_raw[15:12], w_raw[15:12], w_raw[3:0], w_raw[3:0],
                                  w_raw[7:4], w_raw[7:4], w_raw[11:8], w_raw[11:8]};
                end
                MODE_BGR555_SWAP: begin
                    color_next = {8'hFF, e_hi, e_mid, e_lo};
                end
                MODE_RGB555: begin
                    color_next = {8'hFF, e_lo, e_mid, e_hi};
                end
                default: begin
                    color_next = '0;
                end
            endcase
        end else begin
            unique case (in_ctl.mode)
                MODE_ARGB4444: begin
                    color_next = {{HALF_W{1'b0}}, in_quot[CH_A], in_quot[CH_R],
                                  in_quot[CH_G], in_quot[CH_B]};
                end
                MODE_BGR555_SWAP: begin
                    color_next = {{HALF_W{1'b0}}, pk_bgr[CH_W-1:0], pk_bgr[HALF_W-1:CH_W]};
                end
                MODE_RGB555: begin
                    color_next = {{HALF_W{1'b0}}, pk_rgb};
                end
                default: begin
                    color_next = '0;
                end
            endcase
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            color_reg <= color_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_color = color_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/palette_color_format_converter.sv -----
// an accepted input word passes the input, divide and output registers in turn before m_valid rises
// throughput: one word per cycle; each stage holds its word while the next one is full
// a bubble anywhere in the pipe is filled even while m_ready is low
// reset (aresetn low, synchronous) empties all stages and sets color_mode to 0
// depends on pcfc_pkg, pcfc_recip_stage, pcfc_assemble_stage
`timescale 1ns / 1ps
`default_nettype none

module palette_color_format_converter (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         cfg_wr_en,
    input  wire [1:0]                   cfg_wr_data,
    input  wire                         s_valid,
    output logic                        s_ready,
    input  wire                         s_operation,
    input  wire [pcfc_pkg::COLOR_W-1:0] s_color_in,
    output logic                        m_valid,
    input  wire                         m_ready,
    output logic [pcfc_pkg::COLOR_W-1:0] m_color_out
);
    import pcfc_pkg::*;

    color_mode_t        mode_reg;
    logic               s1_valid_reg;
    pcfc_ctl_t          s1_ctl_reg;
    logic [COLOR_W-1:0] s1_color_reg;
    logic               s1_ready;

    logic               s2_valid;
    logic               s2_ready;
    pcfc_ctl_t          s2_ctl;
    logic [COLOR_W-1:0] s2_color;
    pcfc_quot_t         s2_quot;

    // mode 3 is not a format, the write is dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= color_mode_t'(MODE_RESET);
        end else if (cfg_wr_en && (cfg_wr_data <= MODE_RGB555)) begin
            mode_reg <= color_mode_t'(cfg_wr_data);
        end
    end

    assign s_ready = !s1_valid_reg || s1_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            s1_ctl_reg.op   <= s_operation;
            s1_ctl_reg.mode <= mode_reg;
            s1_color_reg    <= s_color_in;
        end
    end

    pcfc_recip_stage u_recip (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_valid_reg),
        .in_ready  (s1_ready),
        .in_ctl    (s1_ctl_reg),
        .in_color  (s1_color_reg),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_ctl   (s2_ctl),
        .out_color (s2_color),
        .out_quot  (s2_quot)
    );

    pcfc_assemble_stage u_assemble (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_ctl    (s2_ctl),
        .in_color  (s2_color),
        .in_quot   (s2_quot),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_color (m_color_out)
    );

    // an empty output stage means the whole pipe can move
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with an empty output stage");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> s1_valid_reg)
        else $error("accepted word missing from the input stage");

    // a stalled input stage keeps its word
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s1_ready |=> s1_valid_reg && $stable(s1_color_reg)
            && $stable(s1_ctl_reg))
        else $error("input stage word lost during stall");

endmodule

`default_nettype wire
